[src/bpq_pkg.sv]
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared widths, status codes and word types for the bounded priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // default capacity of the queue
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // fixed field widths
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // request kinds
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // one stored entry
  typedef struct packed {
    logic        [PRI_W-1:0]  pri;
    logic signed [DATA_W-1:0] data;
  } entry_t;

endpackage

[src/bpq_req_if.sv]
// ----------------------------------------------------------------------------
// bpq_req_if
// Request channel of the priority queue: insert or remove words.
// ----------------------------------------------------------------------------
interface bpq_req_if;

  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic        [bpq_pkg::PRI_W-1:0]  priority_req;
  logic signed [bpq_pkg::DATA_W-1:0] payload;

  modport source (output valid, kind, priority_req, payload, input ready);
  modport sink   (input valid, kind, priority_req, payload, output ready);

endinterface

[src/bpq_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpq_rsp_if
// Response channel of the priority queue: one status word per request.
// ----------------------------------------------------------------------------
interface bpq_rsp_if;

  logic                               valid;
  logic                               ready;
  logic        [bpq_pkg::STATUS_W-1:0] status;
  logic        [bpq_pkg::PRI_W-1:0]    out_priority;
  logic signed [bpq_pkg::DATA_W-1:0]   out_payload;
  logic        [bpq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);

endinterface

[src/bounded_priority_queue.sv]
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Fixed-capacity priority queue kept as a compact sorted array in one memory.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries sorted by descending priority,
// oldest first among equal priorities, so entry 0 is always the next to leave.
// One request is worked on at a time and the request side is not ready until
// it is finished. All work goes through a single memory with one read and one
// write port, and each entry moved is first read, then compared and written.
// An insert into a full queue or a remove from an empty one goes straight to
// the response without a walk. The next request can be taken at the edge after
// the response appears. The response sits in an output register, so a new
// request is taken while the last response still waits to be read; a result
// that finds the output register still full waits until it is read.
module bounded_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = bpq_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bpq_req_if.sink   req,
  bpq_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_REM_RD  = 6'b001000,
    S_REM_MV  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] fill, fill_next;

  // request held while the walk runs
  logic        [bpq_pkg::PRI_W-1:0]  ins_pri;
  logic signed [bpq_pkg::DATA_W-1:0] ins_data;

  // result waiting for the output register
  bpq_pkg::status_t                  res_status, res_status_next;
  logic        [bpq_pkg::PRI_W-1:0]  res_pri, res_pri_next;
  logic signed [bpq_pkg::DATA_W-1:0] res_data, res_data_next;

  // output register
  logic                              out_valid;
  bpq_pkg::status_t                  out_status;
  logic        [bpq_pkg::PRI_W-1:0]  out_pri;
  logic signed [bpq_pkg::DATA_W-1:0] out_data;
  logic        [bpq_pkg::OCC_W-1:0]  out_occ;

  // entry memory
  bpq_pkg::entry_t entry_mem [QUEUE_DEPTH];
  bpq_pkg::entry_t rd_q;
  bpq_pkg::entry_t wr_word;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            mem_we;

  logic            req_fire;
  logic            out_load;
  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   idx_inc;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);
  assign idx_dec  = idx - 1'b1;
  assign idx_inc  = idx + 1'b1;

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[wr_addr] <= wr_word;
    end
    rd_q <= entry_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    fill_next       = fill;
    res_status_next = res_status;
    res_pri_next    = res_pri;
    res_data_next   = res_data;
    rd_addr         = idx[AW-1:0];
    wr_addr         = idx[AW-1:0];
    wr_word         = '{pri: ins_pri, data: ins_data};
    mem_we          = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          res_pri_next  = '0;
          res_data_next = '0;
          if (req.kind == bpq_pkg::KIND_INSERT) begin
            if (fill == DEPTH_C) begin
              res_status_next = bpq_pkg::ST_FULL;
              state_next      = S_DONE;
            end else begin
              idx_next   = fill;
              state_next = S_INS_RD;
            end
          end else begin
            if (fill == '0) begin
              res_status_next = bpq_pkg::ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              idx_next   = '0;
              state_next = S_REM_RD;
            end
          end
        end
      end

      // look at the entry just above the hole, or drop in at the head
      S_INS_RD: begin
        if (idx == '0) begin
          mem_we          = 1'b1;
          fill_next       = fill + 1'b1;
          res_status_next = bpq_pkg::ST_INSERTED;
          state_next      = S_DONE;
        end else begin
          rd_addr    = idx_dec[AW-1:0];
          state_next = S_INS_CMP;
        end
      end

      // equal or higher priority stays ahead, otherwise it moves down
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_q.pri >= ins_pri) begin
          fill_next       = fill + 1'b1;
          res_status_next = bpq_pkg::ST_INSERTED;
          state_next      = S_DONE;
        end else begin
          wr_word    = rd_q;
          idx_next   = idx_dec;
          state_next = S_INS_RD;
        end
      end

      S_REM_RD: begin
        state_next = S_REM_MV;
      end

      // head goes to the result, the rest moves up one place
      S_REM_MV: begin
        if (idx == '0) begin
          res_pri_next  = rd_q.pri;
          res_data_next = rd_q.data;
        end else begin
          mem_we  = 1'b1;
          wr_addr = idx_dec[AW-1:0];
          wr_word = rd_q;
        end
        idx_next = idx_inc;
        if (idx_inc == fill) begin
          fill_next       = fill - 1'b1;
          res_status_next = bpq_pkg::ST_REMOVED;
          state_next      = S_DONE;
        end else begin
          state_next = S_REM_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      ins_pri  <= req.priority_req;
      ins_data <= req.payload;
    end
    res_status <= res_status_next;
    res_pri    <= res_pri_next;
    res_data   <= res_data_next;
    if (out_load) begin
      out_status <= res_status;
      out_pri    <= res_pri;
      out_data   <= res_data;
      out_occ    <= bpq_pkg::OCC_W'(fill);
    end
  end

  // response word
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_priority = out_pri;
  assign rsp.out_payload  = out_data;
  assign rsp.occupancy    = out_occ;

  // count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("fill count above capacity");

  // writes stay inside the occupied part plus the insert slot
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(wr_addr) <= fill))
    else $error("memory write beyond occupied entries");

  // the count only changes at the end of a walk
  a_fill_change: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> $past(state == S_INS_RD || state == S_INS_CMP
                                     || state == S_REM_MV))
    else $error("fill count changed outside a walk");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded priority queue.
// ----------------------------------------------------------------------------
// Request words (inserts and removes) are queued by a stimulus block and
// driven by a clocked driver. A local sorted-array model of the queue works
// out the status word each accepted request should produce. A clocked monitor
// compares every response word, field by field, with the oldest expectation.
// The run starts with a short directed sequence (empty queue, extreme
// priorities and data, equal priorities) and then moves to random bursts that
// lean towards inserts or removes, so the queue both fills up and runs dry.
// It goes through phases of sender idling and receiver stalling, and has one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = bpq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned WATCH_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned PHASE_WORDS  = 150;

  // one request word as queued for the driver
  typedef struct packed {
    bpq_pkg::kind_t                    kind;
    logic        [bpq_pkg::PRI_W-1:0]  pri;
    logic signed [bpq_pkg::DATA_W-1:0] data;
  } request_t;

  // one response word as predicted
  typedef struct packed {
    bpq_pkg::status_t                  status;
    logic        [bpq_pkg::PRI_W-1:0]  pri;
    logic signed [bpq_pkg::DATA_W-1:0] data;
    logic        [bpq_pkg::OCC_W-1:0]  occ;
  } response_t;

  logic clk;
  logic rst;

  bpq_req_if req_ch ();
  bpq_rsp_if rsp_ch ();

  bounded_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // words waiting to be driven, and responses still owed by the block
  request_t    pending_words[$];
  response_t   owed_responses[$];
  request_t    offered_word;

  // local copy of the queue contents
  bpq_pkg::entry_t held_entries[DEPTH];
  int unsigned     held_count;

  // idling controls and run bookkeeping
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned n_inserted, n_full, n_removed, n_empty, peak_occ;

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sorted-array queue: apply one request and return the expected response
  function automatic response_t apply_request(request_t rq);
    response_t   res;
    int unsigned pos;
    res.status = bpq_pkg::ST_INSERTED;
    res.pri    = '0;
    res.data   = '0;
    if (rq.kind == bpq_pkg::KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = bpq_pkg::ST_FULL;
      end else begin
        // new entry goes behind everything of equal or higher priority
        pos = 0;
        while (pos < held_count && held_entries[pos].pri >= rq.pri) pos++;
        for (int unsigned k = held_count; k > pos; k--) held_entries[k] = held_entries[k-1];
        held_entries[pos].pri  = rq.pri;
        held_entries[pos].data = rq.data;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = bpq_pkg::ST_EMPTY;
      end else begin
        // head leaves, the rest close up
        res.status = bpq_pkg::ST_REMOVED;
        res.pri    = held_entries[0].pri;
        res.data   = held_entries[0].data;
        for (int unsigned k = 1; k < held_count; k++) held_entries[k-1] = held_entries[k];
        held_count--;
      end
    end
    res.occ = held_count[bpq_pkg::OCC_W-1:0];
    return res;
  endfunction

  // driver: offers queued words, predicts each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_responses.push_back(apply_request(offered_word));
        idle_cycles = 0;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word        = pending_words.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.kind         <= offered_word.kind;
          req_ch.priority_req <= offered_word.pri;
          req_ch.payload      <= offered_word.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks response words, drives ready with stalls and hold-off
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles = 0;
        if (owed_responses.size() == 0) begin
          $error("response word with nothing expected (status %0d)", rsp_ch.status);
          error_count++;
        end else begin
          want = owed_responses.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.out_priority !== want.pri) begin
            $error("out_priority: expected %0d, got %0d", want.pri, rsp_ch.out_priority);
            error_count++;
          end
          if (rsp_ch.out_payload !== want.data) begin
            $error("out_payload: expected %0d, got %0d", want.data, rsp_ch.out_payload);
            error_count++;
          end
          if (rsp_ch.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, rsp_ch.occupancy);
            error_count++;
          end
          case (want.status)
            bpq_pkg::ST_INSERTED: n_inserted++;
            bpq_pkg::ST_FULL:     n_full++;
            bpq_pkg::ST_REMOVED:  n_removed++;
            default:              n_empty++;
          endcase
          if (32'(want.occ) > peak_occ) peak_occ = 32'(want.occ);
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if (!(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCH_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic add_word(bpq_pkg::kind_t k, logic [bpq_pkg::PRI_W-1:0] p,
                          logic signed [bpq_pkg::DATA_W-1:0] d);
    request_t w;
    w.kind = k;
    w.pri  = p;
    w.data = d;
    pending_words.push_back(w);
  endtask

  // random bursts, each leaning towards inserts, removes or neither
  task automatic add_random(int unsigned n);
    int unsigned left;
    int unsigned run;
    int unsigned ins_pct;
    logic [bpq_pkg::PRI_W-1:0] p;
    left = n;
    while (left > 0) begin
      run = $urandom_range(50, 20);
      if (run > left) run = left;
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      for (int unsigned i = 0; i < run; i++) begin
        if ($urandom_range(99) < ins_pct) begin
          // narrow ranges give plenty of equal priorities
          case ($urandom_range(3))
            0:       p = bpq_pkg::PRI_W'($urandom_range(3));
            1:       p = bpq_pkg::PRI_W'($urandom_range(255, 252));
            default: p = bpq_pkg::PRI_W'($urandom_range(255));
          endcase
          add_word(bpq_pkg::KIND_INSERT, p, $urandom);
        end else begin
          p = bpq_pkg::PRI_W'($urandom_range(255));
          add_word(bpq_pkg::KIND_REMOVE, p, $urandom);
        end
      end
      left -= run;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || req_ch.valid || owed_responses.size() > 0)
      @(posedge clk);
  endtask

  // stimulus and phase control
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = bpq_pkg::KIND_INSERT;
    req_ch.priority_req = '0;
    req_ch.payload      = '0;
    rsp_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_request        = 1'b0;
    held_count          = 0;
    error_count         = 0;
    n_inserted          = 0;
    n_full              = 0;
    n_removed           = 0;
    n_empty             = 0;
    peak_occ            = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, extremes, equal priorities, then emptied again
    add_word(bpq_pkg::KIND_REMOVE, 8'hff, 32'h7fffffff);
    add_word(bpq_pkg::KIND_INSERT, 8'd0,   32'h80000000);
    add_word(bpq_pkg::KIND_INSERT, 8'd255, 32'h7fffffff);
    add_word(bpq_pkg::KIND_INSERT, 8'd128, 32'hffffffff);
    add_word(bpq_pkg::KIND_INSERT, 8'd128, 32'h00000000);
    add_word(bpq_pkg::KIND_INSERT, 8'd128, 32'h55555555);
    add_word(bpq_pkg::KIND_INSERT, 8'd0,   32'h12345678);
    add_word(bpq_pkg::KIND_INSERT, 8'd255, 32'haaaaaaaa);
    add_word(bpq_pkg::KIND_INSERT, 8'd1,   32'h00000001);
    repeat (9) add_word(bpq_pkg::KIND_REMOVE, 8'd0, 32'h0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      add_random(PHASE_WORDS);
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) hold_request = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_responses.size() > 0) begin
      $error("%0d response words never arrived", owed_responses.size());
      error_count++;
    end

    $display("covered: %0d inserts, %0d rejected when full, %0d removes, %0d on empty",
             n_inserted, n_full, n_removed, n_empty);
    $display("peak occupancy %0d of %0d, over four idling and stalling phases",
             peak_occ, DEPTH);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/bpq_pkg.sv
src/bpq_req_if.sv
src/bpq_rsp_if.sv
src/bounded_priority_queue.sv
tb/testbench.sv
